// ===== hw/rtl/lcgr_pkg.sv =====
package lcgr_pkg;

    // Generator constants.
    localparam logic [31:0] LcgMul    = 32'd214013;
    localparam logic [31:0] LcgInc    = 32'd2531011;
    localparam logic [32:0] WideSpan  = 33'd32768;

    // The combined draw is 31 bits wide, one divider step per bit.
    localparam int DrawBits = 31;
    localparam int CntBits  = $clog2(DrawBits);
    localparam logic [CntBits-1:0] LastStep = CntBits'(DrawBits - 1);

    // Request payload.
    typedef struct packed {
        logic signed [31:0] range_low;
        logic signed [31:0] range_high;
    } t_in;

    // Result payload.
    typedef struct packed {
        logic signed [31:0] value;
        logic               range_error;
    } t_out;

    // Controller states.
    typedef enum logic [2:0] {
        S_IDLE,
        S_DRAW1,
        S_DRAW2,
        S_DIV,
        S_LOAD
    } t_state;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic take;
        logic draw1;
        logic draw2;
        logic div_step;
        logic out_load;
    } t_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic wide;
        logic div_last;
    } t_status;

endpackage

// ===== hw/rtl/lcgr_ctrl.sv =====
module lcgr_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_ready,
    output logic             o_out_valid,
    input  logic             i_out_ready,
    output lcgr_pkg::t_cmd   o_cmd,
    input  lcgr_pkg::t_status i_status
);

    lcgr_pkg::t_state r_state;
    lcgr_pkg::t_state n_state;
    logic             r_out_valid;
    logic             n_out_valid;
    logic             w_out_free;

    // The result register can take a new value when empty or being drained.
    assign w_out_free = !r_out_valid || i_out_ready;

    // Next-state logic.
    always_comb begin
        n_state = r_state;
        case (r_state)
            lcgr_pkg::S_IDLE: begin
                if (i_in_valid) n_state = lcgr_pkg::S_DRAW1;
            end
            lcgr_pkg::S_DRAW1: begin
                n_state = i_status.wide ? lcgr_pkg::S_DRAW2 : lcgr_pkg::S_DIV;
            end
            lcgr_pkg::S_DRAW2: begin
                n_state = lcgr_pkg::S_DIV;
            end
            lcgr_pkg::S_DIV: begin
                if (i_status.div_last) n_state = lcgr_pkg::S_LOAD;
            end
            lcgr_pkg::S_LOAD: begin
                if (w_out_free) n_state = lcgr_pkg::S_IDLE;
            end
            default: begin
                n_state = lcgr_pkg::S_IDLE;
            end
        endcase
    end

    // Command outputs.
    always_comb begin
        o_cmd          = '0;
        o_in_ready     = 1'b0;
        case (r_state)
            lcgr_pkg::S_IDLE: begin
                o_in_ready = 1'b1;
                o_cmd.take = i_in_valid;
            end
            lcgr_pkg::S_DRAW1: begin
                o_cmd.draw1 = 1'b1;
            end
            lcgr_pkg::S_DRAW2: begin
                o_cmd.draw2 = 1'b1;
            end
            lcgr_pkg::S_DIV: begin
                o_cmd.div_step = 1'b1;
            end
            lcgr_pkg::S_LOAD: begin
                o_cmd.out_load = w_out_free;
            end
            default: begin
                o_cmd = '0;
            end
        endcase
    end

    // A load fills the result register; a transfer on the output empties it.
    always_comb begin
        n_out_valid = r_out_valid;
        if (o_cmd.out_load) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= lcgr_pkg::S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_out_valid = r_out_valid;

endmodule

// ===== hw/rtl/lcgr_datapath.sv =====
module lcgr_datapath (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_seed_we,
    input  logic [31:0]       i_seed,
    input  lcgr_pkg::t_in     i_in_data,
    input  lcgr_pkg::t_cmd    i_cmd,
    output lcgr_pkg::t_status o_status,
    output lcgr_pkg::t_out    o_out_data
);

    logic [31:0]                  r_lcg;
    logic [31:0]                  n_lcg;
    logic [31:0]                  r_lo;
    logic [32:0]                  r_diff;
    logic [32:0]                  r_mod;
    logic [32:0]                  r_rem;
    logic [lcgr_pkg::DrawBits-1:0] r_quot;
    logic [lcgr_pkg::CntBits-1:0] r_cnt;
    lcgr_pkg::t_out               r_out;

    logic [32:0] w_span;
    logic [33:0] w_dp1;
    logic [33:0] w_mod_full;
    logic [33:0] w_trial;
    logic        w_fits;

    // Generator step: one multiply and add, truncated to 32 bits.
    assign n_lcg = r_lcg * lcgr_pkg::LcgMul + lcgr_pkg::LcgInc;

    // Span and modulus from the registered 33-bit bound difference.
    assign w_span     = r_diff[32] ? (33'd0 - r_diff) : r_diff;
    assign w_dp1      = {r_diff[32], r_diff} + 34'd1;
    assign w_mod_full = w_dp1[33] ? (34'd0 - w_dp1) : w_dp1;

    // Restoring divider step: shift in the next draw bit, subtract if it fits.
    assign w_trial = {r_rem, r_quot[lcgr_pkg::DrawBits-1]};
    assign w_fits  = w_trial >= {1'b0, r_mod};

    assign o_status.wide     = w_span >= lcgr_pkg::WideSpan;
    assign o_status.div_last = r_cnt == lcgr_pkg::LastStep;

    // Generator state: a seed write reloads it, each draw advances it.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lcg <= 32'd0;
        end else if (i_seed_we) begin
            r_lcg <= i_seed;
        end else if (i_cmd.draw1 || i_cmd.draw2) begin
            r_lcg <= n_lcg;
        end
    end

    // Request capture, draws and division.
    always_ff @(posedge i_clk) begin
        if (i_cmd.take) begin
            r_lo   <= i_in_data.range_low;
            r_diff <= {i_in_data.range_high[31], i_in_data.range_high}
                      - {i_in_data.range_low[31], i_in_data.range_low};
        end
        if (i_cmd.draw1) begin
            r_mod  <= w_mod_full[32:0];
            r_rem  <= 33'd0;
            r_cnt  <= '0;
            r_quot <= {16'd0, n_lcg[30:16]};
        end
        if (i_cmd.draw2) begin
            r_quot[30:16] <= n_lcg[30:16];
        end
        if (i_cmd.div_step) begin
            r_rem  <= w_fits ? 33'(w_trial - {1'b0, r_mod}) : w_trial[32:0];
            r_quot <= {r_quot[lcgr_pkg::DrawBits-2:0], 1'b0};
            r_cnt  <= r_cnt + 1'b1;
        end
    end

    // Result register: remainder plus lower bound, or zero on a zero modulus.
    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            if (r_mod == 33'd0) begin
                r_out.value       <= 32'sd0;
                r_out.range_error <= 1'b1;
            end else begin
                r_out.value       <= r_rem[31:0] + r_lo;
                r_out.range_error <= 1'b0;
            end
        end
    end

    assign o_out_data = r_out;

endmodule

// ===== hw/rtl/lcg_random_in_range.sv =====
// Random integer in a requested range from a 32-bit linear congruential
// generator (state * 214013 + 2531011).
// Request channel: i_in_valid / o_in_ready carry range_low and range_high.
// Result channel: o_out_valid / i_out_ready carry value and range_error;
// range_error is set, with value zero, when high is one below low.
// Seed port: a pulse on i_seed_we loads i_seed into the generator state;
// write it only while no request is in flight.
// Sequence: after the request transfer the block draws once for a span
// below 32768 and twice for a wider span, runs the 31-step restoring
// divider at one draw bit per cycle, then loads the result register.
// A new request can be taken in the cycle after the result is loaded.
// The result sits in its own register: when the receiver stalls, the next
// request is still taken and computed, and it waits only for the load.
// Reset clears the generator state to zero and empties the result register.
module lcg_random_in_range (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_seed_we,
    input  logic [31:0]    i_seed,
    input  logic           i_in_valid,
    output logic           o_in_ready,
    input  lcgr_pkg::t_in  i_in_data,
    output logic           o_out_valid,
    input  logic           i_out_ready,
    output lcgr_pkg::t_out o_out_data
);

    lcgr_pkg::t_cmd    w_cmd;
    lcgr_pkg::t_status w_status;

    lcgr_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_cmd       (w_cmd),
        .i_status    (w_status)
    );

    lcgr_datapath u_datapath (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_seed_we  (i_seed_we),
        .i_seed     (i_seed),
        .i_in_data  (i_in_data),
        .i_cmd      (w_cmd),
        .o_status   (w_status),
        .o_out_data (o_out_data)
    );

    // Once a request is taken the block is busy on the next cycle.
    a_busy_after_take: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> !o_in_ready)
        else $error("request taken while a request is in flight");

    // A result load never overwrites a result that has not been transferred.
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.out_load |-> (!o_out_valid || i_out_ready))
        else $error("result register overwritten");

    // A zero modulus result carries value zero.
    a_error_value: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_data.range_error) |-> (o_out_data.value == 32'sd0))
        else $error("range error with nonzero value");

    // Reset leaves the block idle with no result pending.
    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> (o_in_ready && !o_out_valid))
        else $error("block not idle after reset");

endmodule

// ===== verif/testbench.sv =====
module testbench;

    localparam int ResetCycles    = 8;
    localparam int SettleCycles   = 40;
    localparam int IdleLimit      = 2000;
    localparam int RandomPerPhase = 280;
    localparam int ReportLimit    = 10;

    localparam logic signed [31:0] MinInt = 32'sh8000_0000;
    localparam logic signed [31:0] MaxInt = 32'sh7FFF_FFFF;

    // One row of the directed table; want is used only when typed is set.
    typedef struct {
        lcgr_pkg::t_in  req;
        bit             typed;
        lcgr_pkg::t_out want;
    } t_dir_row;

    logic i_clk = 1'b0;
    logic i_rst_n;
    logic i_seed_we;
    logic [31:0] i_seed;
    logic i_in_valid;
    logic o_in_ready;
    lcgr_pkg::t_in  i_in_data;
    logic o_out_valid;
    logic i_out_ready;
    lcgr_pkg::t_out o_out_data;

    // Generator copy and seed register copy used for prediction.
    logic [31:0] seed_reg;
    logic [31:0] gen_state;

    lcgr_pkg::t_out pending_results[$];
    t_dir_row       directed_rows[$];

    bit no_idle = 1'b0;
    int requests_sent = 0;
    int results_checked = 0;
    int flagged_results = 0;
    int mismatches = 0;
    int seed_writes = 0;
    int idle_cycles = 0;
    int stall_left = 0;

    always #5 i_clk = ~i_clk;

    lcg_random_in_range i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_seed_we   (i_seed_we),
        .i_seed      (i_seed),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data)
    );

    // Advance the generator once and return the 15-bit draw.
    function automatic logic [14:0] lcg_advance();
        gen_state = gen_state * lcgr_pkg::LcgMul + lcgr_pkg::LcgInc;
        return gen_state[30:16];
    endfunction

    // Expected result of one request; bound differences are kept at 64 bits.
    function automatic lcgr_pkg::t_out draw_in_range(lcgr_pkg::t_in req);
        longint lo;
        longint hi;
        longint diff;
        longint span;
        longint modulus;
        longint unsigned draw;
        longint unsigned rem;
        lcgr_pkg::t_out res;
        lo = {{32{req.range_low[31]}}, req.range_low};
        hi = {{32{req.range_high[31]}}, req.range_high};
        diff = hi - lo;
        span = (diff < 0) ? -diff : diff;
        modulus = diff + 1;
        if (modulus < 0) begin
            modulus = -modulus;
        end
        draw = {49'd0, lcg_advance()};
        if (span >= longint'(lcgr_pkg::WideSpan)) begin
            draw = draw | {33'd0, lcg_advance(), 16'd0};
        end
        if (modulus == 0) begin
            res.value = '0;
            res.range_error = 1'b1;
        end else begin
            rem = draw % longint'(modulus);
            res.value = rem[31:0] + lo[31:0];
            res.range_error = 1'b0;
        end
        return res;
    endfunction

    function automatic int pick_wait();
        return no_idle ? 0 : $urandom_range(0, 4);
    endfunction

    function automatic void add_row(input logic signed [31:0] lo,
                                    input logic signed [31:0] hi,
                                    input bit typed, input logic signed [31:0] val,
                                    input bit err);
        t_dir_row row;
        row.req.range_low = lo;
        row.req.range_high = hi;
        row.typed = typed;
        row.want.value = val;
        row.want.range_error = err;
        directed_rows.push_back(row);
    endfunction

    // Random request: mostly ordinary spans, plus reversed, equal, zero-modulus
    // and corner bounds.
    function automatic lcgr_pkg::t_in random_range();
        lcgr_pkg::t_in r;
        logic [31:0] corners[5];
        corners[0] = MinInt;
        corners[1] = MaxInt;
        corners[2] = '0;
        corners[3] = '1;
        corners[4] = $urandom();
        r.range_low = $urandom();
        case ($urandom_range(0, 9))
            0, 1, 2, 3: r.range_high = r.range_low + $urandom_range(0, 32767);
            4, 5: r.range_high = $urandom();
            6: r.range_high = r.range_low - $urandom_range(2, 40000);
            7: r.range_high = r.range_low;
            8: r.range_high = r.range_low - 1;
            default: begin
                r.range_low = corners[$urandom_range(0, 4)];
                r.range_high = corners[$urandom_range(0, 4)];
            end
        endcase
        return r;
    endfunction

    // Lower valid and wait until every expected result has come back.
    task automatic settle_idle();
        i_in_valid <= 1'b0;
        do @(posedge i_clk); while (pending_results.size() != 0);
    endtask

    // Offer one request after a random gap that may be zero, and record its expectation on transfer.
    task automatic send_request(input lcgr_pkg::t_in req, input bit typed,
                                input lcgr_pkg::t_out want);
        int gap;
        lcgr_pkg::t_out predicted;
        gap = pick_wait();
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_data <= req;
        do @(posedge i_clk); while (!o_in_ready);
        predicted = draw_in_range(req);
        pending_results.push_back(typed ? want : predicted);
        requests_sent++;
    endtask

    // Seed writes happen only with the block idle.
    task automatic load_seed(input logic [31:0] value);
        settle_idle();
        repeat (SettleCycles) @(posedge i_clk);
        i_seed_we <= 1'b1;
        i_seed <= value;
        @(posedge i_clk);
        i_seed_we <= 1'b0;
        seed_reg = value;
        gen_state = seed_reg;
        seed_writes++;
    endtask

    // Result side: random stalls on ready, and a check on every transfer.
    always @(posedge i_clk) begin
        lcgr_pkg::t_out want;
        int n;
        if (!i_rst_n) begin
            i_out_ready <= 1'b0;
            stall_left <= 0;
        end else if (o_out_valid && i_out_ready) begin
            if (pending_results.size() == 0) begin
                mismatches++;
                if (mismatches <= ReportLimit) begin
                    $display("result transfer with nothing pending: value %0d error %0b",
                             o_out_data.value, o_out_data.range_error);
                end
            end else begin
                want = pending_results.pop_front();
                if (o_out_data.value !== want.value ||
                    o_out_data.range_error !== want.range_error) begin
                    mismatches++;
                    if (mismatches <= ReportLimit) begin
                        $display("result %0d: expected value %0d error %0b,",
                                 results_checked, want.value, want.range_error,
                                 " got value %0d error %0b",
                                 o_out_data.value, o_out_data.range_error);
                    end
                end
            end
            if (o_out_data.range_error) begin
                flagged_results++;
            end
            results_checked++;
            n = pick_wait();
            stall_left <= n;
            i_out_ready <= (n == 0);
        end else if (stall_left != 0) begin
            stall_left <= stall_left - 1;
            i_out_ready <= (stall_left == 1);
        end else begin
            i_out_ready <= 1'b1;
        end
    end

    // Watchdog on cycles without any transfer.
    always @(posedge i_clk) begin
        if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles + 1 >= IdleLimit) begin
            $display("no transfer for %0d cycles, %0d results still pending",
                     IdleLimit, pending_results.size());
            $display("CHECK FAILED");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin
        logic [31:0] phase_seeds[5];
        lcgr_pkg::t_out none;
        none = '0;
        i_rst_n <= 1'b0;
        i_seed_we <= 1'b0;
        i_seed <= '0;
        i_in_valid <= 1'b0;
        i_in_data <= '0;
        seed_reg = '0;
        gen_state = '0;

        // Directed rows: a span of one gives back the lower bound, and a high
        // bound one below the low bound raises the range error.
        add_row(0, 0, 1, 0, 0);
        add_row(5, 4, 1, 0, 1);
        add_row(MinInt, MaxInt, 0, 0, 0);
        add_row(MaxInt, MinInt, 0, 0, 0);
        add_row(MinInt, MinInt, 1, MinInt, 0);
        add_row(MaxInt, MaxInt, 1, MaxInt, 0);
        add_row(0, -1, 1, 0, 1);
        add_row(MaxInt, MaxInt - 1, 1, 0, 1);
        add_row(-1, -1, 1, -1, 0);
        add_row(2, 0, 1, 2, 0);
        add_row(0, 32767, 0, 0, 0);
        add_row(0, 32768, 0, 0, 0);
        add_row(32767, 0, 0, 0, 0);
        add_row(32768, 0, 0, 0, 0);
        add_row(100, -100, 0, 0, 0);
        add_row(1, 2, 0, 0, 0);
        add_row(MinInt, 0, 0, 0, 0);
        add_row(0, MaxInt, 0, 0, 0);
        add_row(-7, 1000, 0, 0, 0);

        repeat (ResetCycles) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed part runs from the reset state of the generator.
        foreach (directed_rows[k]) begin
            send_request(directed_rows[k].req, directed_rows[k].typed,
                         directed_rows[k].want);
        end

        // Random phases, each with its own seed, starting with all ones and all zeros.
        phase_seeds[0] = 32'hFFFF_FFFF;
        phase_seeds[1] = 32'h0000_0000;
        phase_seeds[2] = $urandom();
        phase_seeds[3] = 32'h8000_0000;
        phase_seeds[4] = $urandom();
        foreach (phase_seeds[p]) begin
            load_seed(phase_seeds[p]);
            for (int n = 0; n < RandomPerPhase; n++) begin
                if (n % 64 == 0) begin
                    no_idle = ($urandom_range(0, 3) == 0);
                end
                if ($urandom_range(0, 99) == 0) begin
                    settle_idle();
                end
                send_request(random_range(), 1'b0, none);
            end
        end

        settle_idle();
        repeat (SettleCycles) @(posedge i_clk);

        $display("Covered %0d requests under %0d seed loads;", requests_sent, seed_writes,
                 " %0d results checked, %0d with range error.",
                 results_checked, flagged_results);
        if (mismatches == 0) begin
            $display("CHECK OK");
        end else begin
            $display("%0d mismatching results", mismatches);
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule
